// ----- rtl/core/rotor_force_moment_accumulator_unit_macros.svh -----
// Assertion helpers for the rotor force and moment accumulator.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ROTOR_FORCE_MOMENT_ACCUMULATOR_UNIT_MACROS_SVH
`define ROTOR_FORCE_MOMENT_ACCUMULATOR_UNIT_MACROS_SVH

// Consequent checked in the same cycle.
`define RFMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle.
`define RFMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rfma_pkg.sv -----
package rfma_pkg;

  typedef struct packed {
    logic signed [31:0] thrust;
    logic [15:0]        tilt_roll;
    logic [15:0]        tilt_pitch;
    logic [15:0]        tilt_yaw;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               spin_reverse;
    logic               is_forward_motor;
    logic               last_rotor;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] force_x;
    logic signed [39:0] force_y;
    logic signed [39:0] force_z;
    logic signed [39:0] moment_x;
    logic signed [39:0] moment_y;
    logic signed [39:0] moment_z;
  } out_item_t;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_YAW_RATIO_LIFT    = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_YAW_RATIO_FORWARD = 8'd1;

  localparam logic [31:0] Q30_ONE = 32'd1073741824;
  localparam logic [31:0] SC1  = 32'd1686629713;
  localparam logic [31:0] SC3  = 32'd693598668;
  localparam logic [31:0] SC5  = 32'd85569306;
  localparam logic [31:0] SC7  = 32'd5026996;
  localparam logic [31:0] SC9  = 32'd172272;
  localparam logic [31:0] SC11 = 32'd3864;

  typedef enum logic [4:0] {
    SRC_T, SRC_T2, SRC_ACC, SRC_SC11,
    SRC_SR, SRC_CR, SRC_SP, SRC_CP, SRC_SY, SRC_CY,
    SRC_X0, SRC_X1, SRC_U0, SRC_U1, SRC_U2,
    SRC_THR, SRC_RATIO, SRC_MAG,
    SRC_F0, SRC_F1, SRC_F2,
    SRC_POS0, SRC_POS1, SRC_POS2, SRC_YM
  } src_e;

  typedef enum logic [3:0] {
    POST_T2, POST_HORN, POST_SINE, POST_Q30, POST_Q30_ADD, POST_Q30_SUB,
    POST_RAW, POST_MOM, POST_YM
  } post_e;

  typedef enum logic [3:0] {
    DST_X0, DST_X1, DST_U0, DST_U1, DST_U2,
    DST_F0, DST_F1, DST_F2, DST_M0, DST_M1, DST_M2
  } dst_e;

  typedef struct packed {
    src_e       a;
    src_e       b;
    post_e      post;
    dst_e       dst;
    logic [2:0] coef;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_WB, ST_ACC, ST_OUT
  } state_e;

  localparam logic [4:0] PC_SINE_END = 5'd6;
  localparam logic [4:0] PC_LAST     = 5'd26;
  localparam logic [2:0] SIDX_LAST   = 3'd5;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic       wb_en;
    logic       acc_en;
    logic       out_load;
    uop_t       uop;
    logic [2:0] sidx;
  } cmd_t;

  typedef struct packed {
    logic last_rotor;
  } stat_t;

  function automatic logic [31:0] horn_coef(input logic [2:0] k);
    logic [31:0] c;
    unique case (k)
      3'd0:    c = SC9;
      3'd1:    c = SC7;
      3'd2:    c = SC5;
      3'd3:    c = SC3;
      default: c = SC1;
    endcase
    return c;
  endfunction

  function automatic uop_t mk_uop(input src_e a, input src_e b, input post_e po,
                                  input dst_e d, input logic [2:0] k);
    uop_t u;
    u.a    = a;
    u.b    = b;
    u.post = po;
    u.dst  = d;
    u.coef = k;
    return u;
  endfunction

  // The sine block (steps 0 to 6) runs once per trig value; the rest runs once.
  function automatic uop_t uop_rom(input logic [4:0] pc);
    uop_t r;
    unique case (pc)
      5'd0:    r = mk_uop(SRC_T,     SRC_T,    POST_T2,      DST_X0, 3'd0);
      5'd1:    r = mk_uop(SRC_T2,    SRC_SC11, POST_HORN,    DST_X0, 3'd0);
      5'd2:    r = mk_uop(SRC_T2,    SRC_ACC,  POST_HORN,    DST_X0, 3'd1);
      5'd3:    r = mk_uop(SRC_T2,    SRC_ACC,  POST_HORN,    DST_X0, 3'd2);
      5'd4:    r = mk_uop(SRC_T2,    SRC_ACC,  POST_HORN,    DST_X0, 3'd3);
      5'd5:    r = mk_uop(SRC_T2,    SRC_ACC,  POST_HORN,    DST_X0, 3'd4);
      5'd6:    r = mk_uop(SRC_T,     SRC_ACC,  POST_SINE,    DST_X0, 3'd0);
      5'd7:    r = mk_uop(SRC_SR,    SRC_SY,   POST_Q30,     DST_U0, 3'd0);
      5'd8:    r = mk_uop(SRC_CR,    SRC_CY,   POST_Q30,     DST_X0, 3'd0);
      5'd9:    r = mk_uop(SRC_X0,    SRC_SP,   POST_Q30_ADD, DST_U0, 3'd0);
      5'd10:   r = mk_uop(SRC_CR,    SRC_SY,   POST_Q30,     DST_X1, 3'd0);
      5'd11:   r = mk_uop(SRC_X1,    SRC_SP,   POST_Q30,     DST_U1, 3'd0);
      5'd12:   r = mk_uop(SRC_SR,    SRC_CY,   POST_Q30_SUB, DST_U1, 3'd0);
      5'd13:   r = mk_uop(SRC_CR,    SRC_CP,   POST_Q30,     DST_U2, 3'd0);
      5'd14:   r = mk_uop(SRC_RATIO, SRC_MAG,  POST_YM,      DST_X0, 3'd0);
      5'd15:   r = mk_uop(SRC_THR,   SRC_U0,   POST_Q30,     DST_F0, 3'd0);
      5'd16:   r = mk_uop(SRC_THR,   SRC_U1,   POST_Q30,     DST_F1, 3'd0);
      5'd17:   r = mk_uop(SRC_THR,   SRC_U2,   POST_Q30,     DST_F2, 3'd0);
      5'd18:   r = mk_uop(SRC_POS1,  SRC_F2,   POST_RAW,     DST_X0, 3'd0);
      5'd19:   r = mk_uop(SRC_POS2,  SRC_F1,   POST_MOM,     DST_M0, 3'd0);
      5'd20:   r = mk_uop(SRC_POS2,  SRC_F0,   POST_RAW,     DST_X0, 3'd0);
      5'd21:   r = mk_uop(SRC_POS0,  SRC_F2,   POST_MOM,     DST_M1, 3'd0);
      5'd22:   r = mk_uop(SRC_POS0,  SRC_F1,   POST_RAW,     DST_X0, 3'd0);
      5'd23:   r = mk_uop(SRC_POS1,  SRC_F0,   POST_MOM,     DST_M2, 3'd0);
      5'd24:   r = mk_uop(SRC_YM,    SRC_U0,   POST_Q30_ADD, DST_M0, 3'd0);
      5'd25:   r = mk_uop(SRC_YM,    SRC_U1,   POST_Q30_ADD, DST_M1, 3'd0);
      default: r = mk_uop(SRC_YM,    SRC_U2,   POST_Q30_ADD, DST_M2, 3'd0);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/rfma_mul.sv -----
module rfma_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  logic signed [67:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/rfma_dpath.sv -----
module rfma_dpath #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rfma_pkg::in_item_t           in_data_i,
  input  logic                         cfg_valid_i,
  input  logic [rfma_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rfma_pkg::CfgDataW-1:0] cfg_data_i,
  input  rfma_pkg::cmd_t               cmd_i,
  output rfma_pkg::stat_t              stat_o,
  output rfma_pkg::out_item_t          out_data_o
);

  localparam int KeepBits = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
  localparam logic [15:0] AngMask = ~16'((32'd1 << (16 - KeepBits)) - 32'd1);

  logic [15:0]        ratio_lift_q, ratio_fwd_q, ratio_q;
  rfma_pkg::in_item_t item_q;
  logic signed [31:0] trig_q [6];
  logic [31:0]        t2_q, acc_q;
  logic signed [33:0] x0_q, x1_q, ym_q;
  logic signed [33:0] u_q [3];
  logic signed [33:0] f_q [3];
  logic signed [39:0] m_q [3];
  logic signed [51:0] w_q;
  logic signed [39:0] sumf_q [3];
  logic signed [39:0] summ_q [3];
  rfma_pkg::out_item_t out_q;

  logic [15:0]        ang, ang_m;
  logic [1:0]         quad;
  logic [30:0]        r_ext, t;
  logic [31:0]        mag;
  logic signed [33:0] op_a, op_b;
  logic signed [67:0] prod;
  logic signed [67:0] prod_rnd;
  logic signed [33:0] q30;
  logic [31:0]        p_hi, s_clamp;
  logic signed [31:0] trig_d;
  logic signed [52:0] diff, diff_rnd;
  logic [47:0]        ym_rnd;
  logic signed [33:0] ym_d;
  logic signed [40:0] cur, q30_val;

  // Phase of the selected angle; odd sidx picks the cosine (quarter turn ahead).
  always_comb begin
    unique case (cmd_i.sidx[2:1])
      2'd0:    ang = item_q.tilt_roll;
      2'd1:    ang = item_q.tilt_pitch;
      default: ang = item_q.tilt_yaw;
    endcase
    ang_m = ang & AngMask;
    quad  = ang_m[15:14] + {1'b0, cmd_i.sidx[0]};
    r_ext = {1'b0, ang_m[13:0], 16'd0};
    t     = quad[0] ? (rfma_pkg::Q30_ONE[30:0] - r_ext) : r_ext;
  end

  assign mag = item_q.thrust[31] ? (~item_q.thrust + 32'd1) : item_q.thrust;

  function automatic logic signed [33:0] sel_op(input rfma_pkg::src_e s);
    logic signed [33:0] v;
    unique case (s)
      rfma_pkg::SRC_T:     v = {3'd0, t};
      rfma_pkg::SRC_T2:    v = {2'd0, t2_q};
      rfma_pkg::SRC_ACC:   v = {2'd0, acc_q};
      rfma_pkg::SRC_SC11:  v = {2'd0, rfma_pkg::SC11};
      rfma_pkg::SRC_SR:    v = 34'(trig_q[0]);
      rfma_pkg::SRC_CR:    v = 34'(trig_q[1]);
      rfma_pkg::SRC_SP:    v = 34'(trig_q[2]);
      rfma_pkg::SRC_CP:    v = 34'(trig_q[3]);
      rfma_pkg::SRC_SY:    v = 34'(trig_q[4]);
      rfma_pkg::SRC_CY:    v = 34'(trig_q[5]);
      rfma_pkg::SRC_X0:    v = x0_q;
      rfma_pkg::SRC_X1:    v = x1_q;
      rfma_pkg::SRC_U0:    v = u_q[0];
      rfma_pkg::SRC_U1:    v = u_q[1];
      rfma_pkg::SRC_U2:    v = u_q[2];
      rfma_pkg::SRC_THR:   v = 34'(item_q.thrust);
      rfma_pkg::SRC_RATIO: v = {18'd0, ratio_q};
      rfma_pkg::SRC_MAG:   v = {2'd0, mag};
      rfma_pkg::SRC_F0:    v = f_q[0];
      rfma_pkg::SRC_F1:    v = f_q[1];
      rfma_pkg::SRC_F2:    v = f_q[2];
      rfma_pkg::SRC_POS0:  v = 34'(item_q.pos_x);
      rfma_pkg::SRC_POS1:  v = 34'(item_q.pos_y);
      rfma_pkg::SRC_POS2:  v = 34'(item_q.pos_z);
      default:             v = ym_q;
    endcase
    return v;
  endfunction

  assign op_a = sel_op(cmd_i.uop.a);
  assign op_b = sel_op(cmd_i.uop.b);

  rfma_mul u_mul (
    .clk_i (clk_i),
    .en_i  (cmd_i.mul_en),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  // Post-processing of the registered product.
  always_comb begin
    prod_rnd = prod + 68'sd536870912;
    q30      = prod_rnd[63:30];
    p_hi     = prod[61:30];
    s_clamp  = (p_hi > rfma_pkg::Q30_ONE) ? rfma_pkg::Q30_ONE : p_hi;
    trig_d   = quad[1] ? -$signed(s_clamp) : $signed(s_clamp);
    diff     = 53'(w_q) - 53'(prod[51:0]);
    diff_rnd = diff + 53'sd2048;
    ym_rnd   = prod[47:0] + 48'd32768;
    ym_d     = item_q.spin_reverse ? -$signed({2'd0, ym_rnd[47:16]})
                                   : $signed({2'd0, ym_rnd[47:16]});
    unique case (cmd_i.uop.dst)
      rfma_pkg::DST_U0: cur = 41'(u_q[0]);
      rfma_pkg::DST_U1: cur = 41'(u_q[1]);
      rfma_pkg::DST_M0: cur = 41'(m_q[0]);
      rfma_pkg::DST_M1: cur = 41'(m_q[1]);
      rfma_pkg::DST_M2: cur = 41'(m_q[2]);
      default:          cur = '0;
    endcase
    unique case (cmd_i.uop.post)
      rfma_pkg::POST_Q30_ADD: q30_val = cur + 41'(q30);
      rfma_pkg::POST_Q30_SUB: q30_val = cur - 41'(q30);
      default:                q30_val = 41'(q30);
    endcase
  end

  function automatic logic signed [39:0] sat_add(input logic signed [39:0] a,
                                                 input logic signed [39:0] b);
    logic signed [40:0] s;
    logic signed [39:0] r;
    s = 41'(a) + 41'(b);
    if (s[40] != s[39]) begin
      r = s[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      r = s[39:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_lift_q <= '0;
      ratio_fwd_q  <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rfma_pkg::CFG_YAW_RATIO_LIFT) begin
        ratio_lift_q <= cfg_data_i[15:0];
      end else if (cfg_index_i == rfma_pkg::CFG_YAW_RATIO_FORWARD) begin
        ratio_fwd_q <= cfg_data_i[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= in_data_i;
      ratio_q <= in_data_i.is_forward_motor ? ratio_fwd_q : ratio_lift_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb_en) begin
      unique case (cmd_i.uop.post)
        rfma_pkg::POST_T2:   t2_q <= p_hi;
        rfma_pkg::POST_HORN: acc_q <= rfma_pkg::horn_coef(cmd_i.uop.coef) - p_hi;
        rfma_pkg::POST_SINE: trig_q[cmd_i.sidx] <= trig_d;
        rfma_pkg::POST_RAW:  w_q <= prod[51:0];
        rfma_pkg::POST_YM:   ym_q <= ym_d;
        rfma_pkg::POST_MOM: begin
          unique case (cmd_i.uop.dst)
            rfma_pkg::DST_M0: m_q[0] <= diff_rnd[51:12];
            rfma_pkg::DST_M1: m_q[1] <= diff_rnd[51:12];
            default:          m_q[2] <= diff_rnd[51:12];
          endcase
        end
        default: begin
          unique case (cmd_i.uop.dst)
            rfma_pkg::DST_X0: x0_q   <= q30_val[33:0];
            rfma_pkg::DST_X1: x1_q   <= q30_val[33:0];
            rfma_pkg::DST_U0: u_q[0] <= q30_val[33:0];
            rfma_pkg::DST_U1: u_q[1] <= q30_val[33:0];
            rfma_pkg::DST_U2: u_q[2] <= q30_val[33:0];
            rfma_pkg::DST_F0: f_q[0] <= q30_val[33:0];
            rfma_pkg::DST_F1: f_q[1] <= q30_val[33:0];
            rfma_pkg::DST_F2: f_q[2] <= q30_val[33:0];
            rfma_pkg::DST_M0: m_q[0] <= q30_val[39:0];
            rfma_pkg::DST_M1: m_q[1] <= q30_val[39:0];
            default:          m_q[2] <= q30_val[39:0];
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        sumf_q[k] <= '0;
        summ_q[k] <= '0;
      end
    end else if (cmd_i.acc_en) begin
      for (int k = 0; k < 3; k++) begin
        sumf_q[k] <= sat_add(sumf_q[k], 40'(f_q[k]));
        summ_q[k] <= sat_add(summ_q[k], m_q[k]);
      end
    end else if (cmd_i.out_load) begin
      for (int k = 0; k < 3; k++) begin
        sumf_q[k] <= '0;
        summ_q[k] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.force_x  <= sumf_q[0];
      out_q.force_y  <= sumf_q[1];
      out_q.force_z  <= sumf_q[2];
      out_q.moment_x <= summ_q[0];
      out_q.moment_y <= summ_q[1];
      out_q.moment_z <= summ_q[2];
    end
  end

  assign stat_o.last_rotor = item_q.last_rotor;
  assign out_data_o        = out_q;

endmodule

// ----- rtl/core/rfma_ctrl.sv -----
module rfma_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  rfma_pkg::stat_t  stat_i,
  output rfma_pkg::cmd_t   cmd_o
);

  rfma_pkg::state_e state_q, state_d;
  logic [4:0]       pc_q, pc_d;
  logic [2:0]       sidx_q, sidx_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, out_free, load;

  assign accept   = in_valid_i && (state_q == rfma_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = (state_q == rfma_pkg::ST_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfma_pkg::ST_IDLE: if (accept) state_d = rfma_pkg::ST_MUL;
      rfma_pkg::ST_MUL:  state_d = rfma_pkg::ST_WB;
      rfma_pkg::ST_WB: begin
        state_d = (pc_q == rfma_pkg::PC_LAST) ? rfma_pkg::ST_ACC : rfma_pkg::ST_MUL;
      end
      rfma_pkg::ST_ACC: begin
        state_d = stat_i.last_rotor ? rfma_pkg::ST_OUT : rfma_pkg::ST_IDLE;
      end
      default: if (load) state_d = rfma_pkg::ST_IDLE;
    endcase
  end

  // Step counter: the sine block repeats once for each of the six trig values.
  always_comb begin
    pc_d   = pc_q;
    sidx_d = sidx_q;
    if (accept) begin
      pc_d   = '0;
      sidx_d = '0;
    end else if (state_q == rfma_pkg::ST_WB) begin
      if (pc_q == rfma_pkg::PC_SINE_END && sidx_q != rfma_pkg::SIDX_LAST) begin
        pc_d   = '0;
        sidx_d = sidx_q + 3'd1;
      end else begin
        pc_d = pc_q + 5'd1;
      end
    end
  end

  always_comb begin
    out_valid_d       = load || (out_valid_q && out_stall_i);
    cmd_o.capture     = accept;
    cmd_o.mul_en      = (state_q == rfma_pkg::ST_MUL);
    cmd_o.wb_en       = (state_q == rfma_pkg::ST_WB);
    cmd_o.acc_en      = (state_q == rfma_pkg::ST_ACC);
    cmd_o.out_load    = load;
    cmd_o.uop         = rfma_pkg::uop_rom(pc_q);
    cmd_o.sidx        = sidx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rfma_pkg::ST_IDLE;
      pc_q        <= '0;
      sidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      sidx_q      <= sidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != rfma_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/rotor_force_moment_accumulator_unit.sv -----
// Rotor force and moment accumulator.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one rotor per item.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns the six
// saturated totals, one item for each rotor marked last_rotor.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes the two yaw ratios;
// cfg_ready_o is always high and out-of-range indexes are ignored.
// Each rotor runs through 62 products on one shared 34x34 multiplier, each
// product a multiply step and a write-back step, then one accumulate step;
// the input stays stalled from the accept until the block is idle again, so
// a new item is taken only after the previous one is through.
// For a last rotor the totals reach the output register in the ST_OUT state
// after the accumulate step, once that register is empty or being drained.
// A result waiting under out_stall_i stays held; a last rotor then waits
// until the register frees before the sums clear and input opens again.
// Reset clears the ratios, the sums and all handshake state.
module rotor_force_moment_accumulator_unit #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rfma_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rfma_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rfma_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rfma_pkg::CfgDataW-1:0] cfg_data_i
);

  rfma_pkg::cmd_t  cmd;
  rfma_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  rfma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rfma_dpath #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/rfma_checker.sv -----
`include "rotor_force_moment_accumulator_unit_macros.svh"

module rfma_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rfma_pkg::out_item_t out_data_o
);

  `RFMA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")
  `RFMA_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after an accepted item")
  `RFMA_ASSERT_IMP(a_result_while_busy, $rose(out_valid_o), $past(in_stall_o), "result appeared while the block was idle")
  `RFMA_ASSERT_IMP(a_no_instant_result, $rose(out_valid_o), !$past(in_valid_i && !in_stall_o), "result appeared right after an accept")

endmodule

bind rotor_force_moment_accumulator_unit rfma_checker u_rfma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
